/* design/irpu_pkg.sv */
// Shared types and constants for the interrupt request priority unit.
`timescale 1ns / 1ps

package irpu_pkg;

    localparam int NUM_VECTORS = 256;
    localparam int VEC_W       = 8;
    localparam int WORD_W      = 64;
    localparam int BIT_W       = 6;
    localparam int NUM_WORDS   = 4;
    localparam int WIDX_W      = 2;
    localparam int DATA_W      = 8;
    localparam int REG_IDX_W   = 1;

    localparam logic [VEC_W-1:0] CLASS_MASK = 8'hf0;

    typedef enum logic [1:0] {
        CMD_RAISE = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_ACK   = 2'd2,
        CMD_EOI   = 2'd3
    } cmd_code_t;

    localparam logic [REG_IDX_W-1:0] REG_TASK_PRIORITY   = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_SPURIOUS_VECTOR = 1'b1;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic write;
        logic scan;
        logic commit;
    } irpu_ctl_t;

    // Datapath to controller status.
    typedef struct packed {
        logic scan_hit;
        logic scan_last;
    } irpu_sts_t;

endpackage

/* design/irpu_dp.sv */
// Datapath: request bitmap, word scanner, priority and configuration registers.
`timescale 1ns / 1ps

module irpu_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  irpu_pkg::irpu_ctl_t               ctl,
    output irpu_pkg::irpu_sts_t               sts,
    input  logic [1:0]                        cmd,
    input  logic [irpu_pkg::VEC_W-1:0]        vector,
    input  logic                              cfg_we,
    input  logic [irpu_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [irpu_pkg::DATA_W-1:0]       cfg_wdata,
    output logic                              pending,
    output logic [irpu_pkg::VEC_W-1:0]        highest_pending,
    output logic [irpu_pkg::VEC_W-1:0]        ack_vector,
    output logic [irpu_pkg::VEC_W-1:0]        processor_priority
);

    logic [irpu_pkg::NUM_WORDS*irpu_pkg::WORD_W-1:0] req_bits_reg;
    logic [1:0]                        cmd_reg;
    logic [irpu_pkg::VEC_W-1:0]        vector_reg;
    logic [irpu_pkg::VEC_W-1:0]        in_service_reg;
    logic [irpu_pkg::VEC_W-1:0]        highest_reg;
    logic                              waiting_reg;
    logic [irpu_pkg::VEC_W-1:0]        priority_reg;
    logic [irpu_pkg::VEC_W-1:0]        ack_vector_reg;
    logic [irpu_pkg::VEC_W-1:0]        task_priority_reg;
    logic [irpu_pkg::VEC_W-1:0]        spurious_reg;
    logic [irpu_pkg::WIDX_W-1:0]       word_idx_reg;
    logic                              found_reg;
    logic [irpu_pkg::VEC_W-1:0]        found_vec_reg;

    logic [irpu_pkg::WORD_W-1:0]       scan_word;
    logic [irpu_pkg::BIT_W-1:0]        scan_bit;
    logic                              is_ack;
    logic                              wr_en;
    logic [irpu_pkg::VEC_W-1:0]        wr_addr;
    logic                              wr_val;

    // Highest set bit of one request word.
    function automatic logic [irpu_pkg::BIT_W-1:0] top_bit(
        input logic [irpu_pkg::WORD_W-1:0] w
    );
        logic [irpu_pkg::BIT_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < irpu_pkg::WORD_W; i++) begin
            if (w[i]) begin
                pos = irpu_pkg::BIT_W'(i);
            end
        end
        return pos;
    endfunction

    assign scan_word = req_bits_reg[word_idx_reg*irpu_pkg::WORD_W +: irpu_pkg::WORD_W];
    assign scan_bit  = top_bit(scan_word);
    assign is_ack    = (cmd_reg == irpu_pkg::CMD_ACK);

    assign sts.scan_hit  = (scan_word != '0);
    assign sts.scan_last = (word_idx_reg == '0);

    // Single write port into the bitmap: command update or grant clear.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = vector_reg;
        wr_val  = 1'b0;
        if (ctl.write) begin
            wr_en = 1'b1;
            case (cmd_reg)
                irpu_pkg::CMD_RAISE: wr_val = 1'b1;
                irpu_pkg::CMD_CLEAR: wr_val = 1'b0;
                irpu_pkg::CMD_EOI:   wr_addr = in_service_reg;
                default:             wr_en = 1'b0;
            endcase
        end else if (ctl.commit && is_ack && found_reg) begin
            wr_en   = 1'b1;
            wr_addr = found_vec_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_bits_reg      <= '0;
            in_service_reg    <= '0;
            highest_reg       <= '0;
            waiting_reg       <= 1'b0;
            priority_reg      <= '0;
            ack_vector_reg    <= '0;
            task_priority_reg <= '0;
            spurious_reg      <= 8'hff;
            cmd_reg           <= irpu_pkg::CMD_RAISE;
            vector_reg        <= '0;
            word_idx_reg      <= '0;
            found_reg         <= 1'b0;
            found_vec_reg     <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    irpu_pkg::REG_TASK_PRIORITY:   task_priority_reg <= cfg_wdata;
                    irpu_pkg::REG_SPURIOUS_VECTOR: spurious_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (ctl.load) begin
                cmd_reg      <= cmd;
                vector_reg   <= vector;
                word_idx_reg <= irpu_pkg::WIDX_W'(irpu_pkg::NUM_WORDS - 1);
                found_reg    <= 1'b0;
            end

            if (wr_en && ({1'b0, wr_addr} < 9'(irpu_pkg::NUM_VECTORS))) begin
                req_bits_reg[wr_addr] <= wr_val;
            end

            if (ctl.write && (cmd_reg == irpu_pkg::CMD_EOI)) begin
                in_service_reg <= '0;
            end

            if (ctl.scan) begin
                if (sts.scan_hit) begin
                    found_reg     <= 1'b1;
                    found_vec_reg <= {word_idx_reg, scan_bit};
                end else if (!sts.scan_last) begin
                    word_idx_reg <= word_idx_reg - 1'b1;
                end
            end

            if (ctl.commit) begin
                if (is_ack) begin
                    waiting_reg <= 1'b0;
                    if (found_reg) begin
                        in_service_reg <= found_vec_reg;
                        ack_vector_reg <= found_vec_reg;
                        if (task_priority_reg[7:4] >= found_vec_reg[7:4]) begin
                            priority_reg <= task_priority_reg;
                        end else begin
                            priority_reg <= found_vec_reg & irpu_pkg::CLASS_MASK;
                        end
                    end else begin
                        ack_vector_reg <= spurious_reg;
                    end
                end else begin
                    waiting_reg    <= found_reg;
                    ack_vector_reg <= '0;
                    if (found_reg) begin
                        highest_reg <= found_vec_reg;
                    end
                end
            end
        end
    end

    assign pending            = waiting_reg;
    assign highest_pending    = highest_reg;
    assign ack_vector         = ack_vector_reg;
    assign processor_priority = priority_reg;

endmodule

/* design/irpu_ctrl.sv */
// Controller state machine that sequences write, scan and commit steps.
`timescale 1ns / 1ps

module irpu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          cmd,
    input  irpu_pkg::irpu_sts_t sts,
    output irpu_pkg::irpu_ctl_t ctl,
    output logic                busy,
    output logic                done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   done_reg;

    always_comb
    begin
        ctl.load   = (state_reg == ST_IDLE) && start;
        ctl.write  = (state_reg == ST_WRITE);
        ctl.scan   = (state_reg == ST_SCAN);
        ctl.commit = (state_reg == ST_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start) begin
                        // Acknowledge scans first and clears the granted bit last.
                        state_reg <= (cmd == irpu_pkg::CMD_ACK) ? ST_SCAN : ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (sts.scan_hit || sts.scan_last) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    state_reg <= ST_IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not make the unit busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(ctl.commit))
        else $error("result strobe without a preceding commit");

endmodule

/* design/interrupt_request_priority_unit_top.sv */
// Top level of the interrupt request priority unit.
`timescale 1ns / 1ps

// The unit keeps a 256-entry interrupt request bitmap and applies one command
// per request: raise, clear, acknowledge or end-of-interrupt. A request is
// taken when start is high and busy is low. A raise, clear or end-of-interrupt
// request first updates the bitmap, then scans the four 64-bit request words
// from the top down (the scan stops at the first nonzero word), then commits,
// and the registered result follows. An acknowledge request skips the update
// step and clears the granted bit at its commit. The result fields are valid
// for exactly one cycle while done is high; the receiver cannot stall them,
// and they are held only until the next request commits. A new request may
// be issued in the same cycle that done is high. Configuration writes through
// cfg_we, cfg_index and cfg_wdata should be made while the unit is idle; that
// they take effect on later requests only is up to the user, as the unit does
// not enforce it.
module interrupt_request_priority_unit_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        cmd,
    input  logic [irpu_pkg::VEC_W-1:0]        vector,
    input  logic                              cfg_we,
    input  logic [irpu_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [irpu_pkg::DATA_W-1:0]       cfg_wdata,
    output logic                              done,
    output logic                              pending,
    output logic [irpu_pkg::VEC_W-1:0]        highest_pending,
    output logic [irpu_pkg::VEC_W-1:0]        ack_vector,
    output logic [irpu_pkg::VEC_W-1:0]        processor_priority
);

    irpu_pkg::irpu_ctl_t ctl;
    irpu_pkg::irpu_sts_t sts;

    // The controller sequences each request; it sees the command code only to
    // pick the order of the bitmap update and the scan.
    irpu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    // The datapath holds all architectural state and drives the result fields.
    irpu_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctl                (ctl),
        .sts                (sts),
        .cmd                (cmd),
        .vector             (vector),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .pending            (pending),
        .highest_pending    (highest_pending),
        .ack_vector         (ack_vector),
        .processor_priority (processor_priority)
    );

endmodule

/* bench/irpu_request_checker.sv */
// Checker for the interrupt request priority unit: predicts every result and compares it.
`timescale 1ns / 1ps

module irpu_request_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [1:0]                        cmd,
    input  logic [irpu_pkg::VEC_W-1:0]        vector,
    input  logic                              cfg_we,
    input  logic [irpu_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [irpu_pkg::DATA_W-1:0]       cfg_wdata,
    input  logic                              done,
    input  logic                              pending,
    input  logic [irpu_pkg::VEC_W-1:0]        highest_pending,
    input  logic [irpu_pkg::VEC_W-1:0]        ack_vector,
    input  logic [irpu_pkg::VEC_W-1:0]        processor_priority,
    output int                                fail_count,
    output int                                outstanding,
    output int                                spurious_grants
);

    typedef struct packed {
        logic                       waiting;
        logic [irpu_pkg::VEC_W-1:0] highest;
        logic [irpu_pkg::VEC_W-1:0] granted;
        logic [irpu_pkg::VEC_W-1:0] prio_level;
    } irq_outcome_t;

    logic [irpu_pkg::NUM_VECTORS-1:0] request_map;
    logic [irpu_pkg::VEC_W-1:0]       in_service;
    logic [irpu_pkg::VEC_W-1:0]       top_request;
    logic [irpu_pkg::VEC_W-1:0]       prio_reg;
    logic [irpu_pkg::VEC_W-1:0]       task_prio;
    logic [irpu_pkg::VEC_W-1:0]       spurious_vec;
    logic                             waiting;

    irq_outcome_t predicted_outcomes[$];
    int           mismatches;
    int           empty_grants;

    function automatic bit find_top_vector(input logic [irpu_pkg::NUM_VECTORS-1:0] map,
                                           output logic [irpu_pkg::VEC_W-1:0] found);
        found = '0;
        for (int i = irpu_pkg::NUM_VECTORS - 1; i >= 0; i--) begin
            if (map[i]) begin
                found = i[irpu_pkg::VEC_W-1:0];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic rescan_map();
        logic [irpu_pkg::VEC_W-1:0] hit;
        if (find_top_vector(request_map, hit)) begin
            top_request = hit;
            waiting     = 1'b1;
        end else begin
            waiting = 1'b0;
        end
    endtask

    task automatic apply_request(input logic [1:0] code, input logic [irpu_pkg::VEC_W-1:0] vec,
                                 output irq_outcome_t outcome);
        logic [irpu_pkg::VEC_W-1:0] hit;
        logic [irpu_pkg::VEC_W-1:0] grant;
        grant = '0;
        case (irpu_pkg::cmd_code_t'(code))
            irpu_pkg::CMD_RAISE:
            begin
                request_map[vec] = 1'b1;
                rescan_map();
            end
            irpu_pkg::CMD_CLEAR:
            begin
                request_map[vec] = 1'b0;
                rescan_map();
            end
            irpu_pkg::CMD_ACK:
            begin
                if (find_top_vector(request_map, hit)) begin
                    request_map[hit] = 1'b0;
                    in_service       = hit;
                    if (task_prio[7:4] >= hit[7:4])
                        prio_reg = task_prio;
                    else
                        prio_reg = hit & irpu_pkg::CLASS_MASK;
                    grant = hit;
                end else begin
                    grant = spurious_vec;
                    empty_grants++;
                end
                // The pending flag drops even if other requests remain.
                waiting = 1'b0;
            end
            default:
            begin
                request_map[in_service] = 1'b0;
                in_service              = '0;
                rescan_map();
            end
        endcase
        outcome = '{waiting, top_request, grant, prio_reg};
    endtask

    task automatic check_result();
        irq_outcome_t want;
        irq_outcome_t got;
        got = '{pending, highest_pending, ack_vector, processor_priority};
        if (predicted_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] result with no request outstanding: %p", $realtime, got);
        end else begin
            want = predicted_outcomes.pop_front();
            if (got.waiting !== want.waiting || got.highest !== want.highest ||
                got.granted !== want.granted || got.prio_level !== want.prio_level) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] mismatch: expected %p, actual %p", $realtime, want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor
        irq_outcome_t outcome;
        if (!rst_n) begin
            request_map     = '0;
            in_service      = '0;
            top_request     = '0;
            prio_reg        = '0;
            waiting         = 1'b0;
            task_prio       = '0;
            spurious_vec    = 8'hff;
            predicted_outcomes.delete();
            mismatches      = 0;
            empty_grants    = 0;
            fail_count      <= 0;
            outstanding     <= 0;
            spurious_grants <= 0;
        end else begin
            // The result of an older request is checked before a new one is queued.
            if (done)
                check_result();
            if (start && !busy) begin
                apply_request(cmd, vector, outcome);
                predicted_outcomes.push_back(outcome);
            end
            if (cfg_we) begin
                if (cfg_index == irpu_pkg::REG_TASK_PRIORITY)
                    task_prio = cfg_wdata;
                else if (cfg_index == irpu_pkg::REG_SPURIOUS_VECTOR)
                    spurious_vec = cfg_wdata;
            end
            fail_count      <= mismatches;
            outstanding     <= predicted_outcomes.size();
            spurious_grants <= empty_grants;
        end
    end

endmodule

/* bench/interrupt_request_priority_unit_top_tb.sv */
// Testbench top for the interrupt request priority unit: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module interrupt_request_priority_unit_top_tb;

    // Number of cycles with neither an accepted request nor a result before
    // the run is declared hung. Every quiet stretch in a correct run, such as a
    // sender gap, stays well under this.
    localparam int QUIET_LIMIT   = 1000;
    localparam int NUM_PHASES    = 13;
    localparam int PHASE_ITEMS   = 150;

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic [1:0]                        cmd;
    logic [irpu_pkg::VEC_W-1:0]        vector;
    logic                              cfg_we;
    logic [irpu_pkg::REG_IDX_W-1:0]    cfg_index;
    logic [irpu_pkg::DATA_W-1:0]       cfg_wdata;
    logic                              done;
    logic                              pending;
    logic [irpu_pkg::VEC_W-1:0]        highest_pending;
    logic [irpu_pkg::VEC_W-1:0]        ack_vector;
    logic [irpu_pkg::VEC_W-1:0]        processor_priority;

    int fail_count;
    int outstanding;
    int spurious_grants;
    int quiet_cycles;
    int cmd_count [4];
    int reg_writes;

    // Knobs of the current random phase: command mix and vector locality.
    int raise_weight;
    int clear_weight;
    int ack_weight;
    int vector_mode;
    logic [irpu_pkg::VEC_W-1:0] vector_base;

    interrupt_request_priority_unit_top u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .cmd                (cmd),
        .vector             (vector),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .done               (done),
        .pending            (pending),
        .highest_pending    (highest_pending),
        .ack_vector         (ack_vector),
        .processor_priority (processor_priority)
    );

    irpu_request_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .cmd                (cmd),
        .vector             (vector),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .done               (done),
        .pending            (pending),
        .highest_pending    (highest_pending),
        .ack_vector         (ack_vector),
        .processor_priority (processor_priority),
        .fail_count         (fail_count),
        .outstanding        (outstanding),
        .spurious_grants    (spurious_grants)
    );

    // 12 ns clock period: 6 ns high, 6 ns low.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: any cycle that moves a request or a result restarts the count.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Writes one configuration register. Only called while the unit is idle.
    task automatic set_register(input logic [irpu_pkg::REG_IDX_W-1:0] idx,
                                input logic [irpu_pkg::DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
        reg_writes++;
    endtask

    // Presents one request and waits for the edge that takes it. The start
    // line is left high so that a following request can go out back to back;
    // end_burst lowers it.
    task automatic issue_request(input irpu_pkg::cmd_code_t code,
                                 input logic [irpu_pkg::VEC_W-1:0] vec);
        @(negedge clk);
        start  = 1'b1;
        cmd    = code;
        vector = vec;
        do
            @(posedge clk);
        while (busy);
        cmd_count[code]++;
    endtask

    task automatic end_burst(input int gap);
        @(negedge clk);
        start = 1'b0;
        repeat (gap) @(negedge clk);
    endtask

    // Waits until every predicted result has been seen, then lets the unit settle.
    task automatic drain();
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [irpu_pkg::VEC_W-1:0] pick_vector();
        logic [irpu_pkg::VEC_W-1:0] v;
        v = irpu_pkg::VEC_W'($urandom_range(0, 255));
        // A fifth of the vectors are always drawn from the full range.
        if ($urandom_range(0, 4) != 0) begin
            case (vector_mode)
                1: v = {vector_base[7:6], v[5:0]};
                2: v = {vector_base[7:4], v[3:0]};
                3: v = {vector_base[7:3], v[2:0]};
                default: ;
            endcase
        end
        return v;
    endfunction

    function automatic irpu_pkg::cmd_code_t pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < raise_weight)
            return irpu_pkg::CMD_RAISE;
        else if (r < raise_weight + clear_weight)
            return irpu_pkg::CMD_CLEAR;
        else if (r < raise_weight + clear_weight + ack_weight)
            return irpu_pkg::CMD_ACK;
        else
            return irpu_pkg::CMD_EOI;
    endfunction

    initial begin
        int burst_left;
        logic [irpu_pkg::DATA_W-1:0] tp_value;
        logic [irpu_pkg::DATA_W-1:0] sv_value;

        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = irpu_pkg::CMD_RAISE;
        vector       = '0;
        cfg_we       = 1'b0;
        cfg_index    = irpu_pkg::REG_TASK_PRIORITY;
        cfg_wdata    = '0;
        quiet_cycles = 0;
        reg_writes   = 0;
        foreach (cmd_count[i])
            cmd_count[i] = 0;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed part, first with the reset register values. An acknowledge
        // on an empty map must return the spurious vector, and end-of-interrupt
        // with nothing in service clears bit 0. The vector field carries noise
        // on commands that ignore it.
        issue_request(irpu_pkg::CMD_ACK, 8'hff);
        issue_request(irpu_pkg::CMD_EOI, 8'haa);
        issue_request(irpu_pkg::CMD_RAISE, 8'd0);
        issue_request(irpu_pkg::CMD_EOI, 8'h55);
        // Word boundaries of the map, a duplicate raise and a clear of a bit
        // that is not set.
        issue_request(irpu_pkg::CMD_RAISE, 8'd255);
        issue_request(irpu_pkg::CMD_RAISE, 8'd0);
        issue_request(irpu_pkg::CMD_RAISE, 8'd128);
        issue_request(irpu_pkg::CMD_RAISE, 8'd127);
        issue_request(irpu_pkg::CMD_RAISE, 8'd64);
        issue_request(irpu_pkg::CMD_RAISE, 8'd63);
        issue_request(irpu_pkg::CMD_RAISE, 8'd192);
        issue_request(irpu_pkg::CMD_RAISE, 8'd255);
        issue_request(irpu_pkg::CMD_CLEAR, 8'd5);
        issue_request(irpu_pkg::CMD_CLEAR, 8'd255);
        // Task priority zero loses to the granted class.
        issue_request(irpu_pkg::CMD_ACK, 8'h00);
        issue_request(irpu_pkg::CMD_RAISE, 8'd200);
        issue_request(irpu_pkg::CMD_EOI, 8'h0f);
        issue_request(irpu_pkg::CMD_ACK, 8'hf0);
        end_burst(1);
        drain();

        // Highest task priority always wins; zero spurious vector.
        set_register(irpu_pkg::REG_TASK_PRIORITY, 8'hff);
        set_register(irpu_pkg::REG_SPURIOUS_VECTOR, 8'h00);
        repeat (7) issue_request(irpu_pkg::CMD_ACK, irpu_pkg::VEC_W'($urandom_range(0, 255)));
        end_burst(1);
        drain();

        // Equal class keeps the task priority, a higher class replaces it.
        set_register(irpu_pkg::REG_TASK_PRIORITY, 8'h50);
        issue_request(irpu_pkg::CMD_RAISE, 8'h5f);
        issue_request(irpu_pkg::CMD_ACK, 8'h00);
        issue_request(irpu_pkg::CMD_RAISE, 8'h60);
        issue_request(irpu_pkg::CMD_ACK, 8'h00);
        end_burst(1);
        drain();

        // Random phases. Each starts from an idle unit with fresh register
        // values, the extremes first, and its own command mix and vector
        // locality so that the map sometimes fills and sometimes empties.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin tp_value = 8'h00; sv_value = 8'hff; end
                1: begin tp_value = 8'hff; sv_value = 8'h00; end
                2: begin tp_value = 8'h80; sv_value = 8'h7f; end
                3: begin tp_value = 8'h7f; sv_value = 8'h80; end
                4: begin tp_value = 8'h0f; sv_value = 8'hf0; end
                5: begin tp_value = 8'hf0; sv_value = 8'h0f; end
                default:
                begin
                    tp_value = irpu_pkg::DATA_W'($urandom_range(0, 255));
                    sv_value = irpu_pkg::DATA_W'($urandom_range(0, 255));
                end
            endcase
            set_register(irpu_pkg::REG_TASK_PRIORITY, tp_value);
            set_register(irpu_pkg::REG_SPURIOUS_VECTOR, sv_value);

            raise_weight = $urandom_range(30, 60);
            clear_weight = $urandom_range(5, 20);
            ack_weight   = $urandom_range(15, 30);
            vector_mode  = $urandom_range(0, 3);
            vector_base  = irpu_pkg::VEC_W'($urandom_range(0, 255));

            // The sender works in bursts: back to back within a burst, then a
            // random gap, so that new requests land on every cycle of the
            // unit's work.
            burst_left = $urandom_range(1, 40);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                issue_request(pick_command(), pick_vector());
                burst_left--;
                if (burst_left == 0) begin
                    end_burst($urandom_range(1, 25));
                    burst_left = $urandom_range(1, 40);
                end
            end
            end_burst(1);
            drain();
        end

        $display("Ran %0d requests: %0d raise, %0d clear, %0d acknowledge, %0d end-of-interrupt.",
                 cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3],
                 cmd_count[irpu_pkg::CMD_RAISE], cmd_count[irpu_pkg::CMD_CLEAR],
                 cmd_count[irpu_pkg::CMD_ACK], cmd_count[irpu_pkg::CMD_EOI]);
        $display("%0d acknowledges found the map empty; %0d register writes were made.",
                 spurious_grants, reg_writes);

        if (fail_count == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
